// ===== design/fcbf_pkg.sv =====
// Shared types and constants for the flow-controlled byte FIFO.
`default_nettype none
package fcbf_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned STAT_W   = 13;
  localparam int unsigned TOT_W    = 32;
  localparam logic [STAT_W-1:0] CAP_RESET = 13'd4096;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 3'd0,
    REQ_READ    = 3'd1,
    REQ_PEEK    = 3'd2,
    REQ_DISCARD = 3'd3,
    REQ_CLOSE   = 3'd4
  } req_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BURST = 1'b1
  } state_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage
`default_nettype wire

// ===== design/fcbf_mem.sv =====
// Byte store: one write port, one read port, registered read data.
`default_nettype none
module fcbf_mem
  import fcbf_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic              clk_i,
  input  wire mem_ctl_t          ctl_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/fcbf_ctrl.sv =====
// Request sequencer: pointers, counters, status and result strobes.
`default_nettype none
module fcbf_ctrl
  import fcbf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned MAX_BURST   = 64,
  parameter int unsigned AW          = 12,
  parameter int unsigned CW          = 13
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [LEN_W-1:0]  length_i,
  input  wire logic              cfg_we_i,
  input  wire logic [STAT_W-1:0] cfg_wdata_i,
  output mem_ctl_t               mem_ctl_o,
  output logic      [AW-1:0]     mem_waddr_o,
  output logic      [AW-1:0]     mem_raddr_o,
  input  wire logic [DATA_W-1:0] mem_rdata_i,
  output logic                   valid_o,
  output logic      [DATA_W-1:0] out_byte_o,
  output logic                   byte_valid_o,
  output logic                   last_o,
  output logic                   accepted_o,
  output logic      [STAT_W-1:0] fill_level_o,
  output logic      [STAT_W-1:0] space_left_o,
  output logic                   input_closed_o,
  output logic                   end_of_stream_o,
  output logic      [TOT_W-1:0]  total_written_o,
  output logic      [TOT_W-1:0]  total_read_o
);

  localparam logic [CW-1:0]    DEPTH_C = CW'(STORE_DEPTH);
  localparam logic [LEN_W-1:0] BURST_C = LEN_W'(MAX_BURST);
  localparam logic [AW-1:0]    LAST_PTR = AW'(STORE_DEPTH - 1);
  localparam logic [AW:0]      DEPTH_P = (AW+1)'(STORE_DEPTH);

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d, tail_q, tail_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     held_q, held_d;
  logic              closed_q, closed_d;
  logic [TOT_W-1:0]  wr_tot_q, wr_tot_d, rd_tot_q, rd_tot_d;
  logic [STAT_W-1:0] cap_q;
  logic [LEN_W-1:0]  remain_q, remain_d;
  logic              valid_q, valid_d, bvalid_q, bvalid_d;
  logic              last_q, last_d, acc_q, acc_d;

  logic              accept;
  logic [CW-1:0]     eff_cap, len_cap, len_full, n_rd, n_dc, n_sel, space;
  logic [LEN_W-1:0]  len_clip;
  logic              wr_ok;
  logic [AW:0]       head_sum;

  assign accept   = start && (state_q == ST_IDLE);
  assign busy     = (state_q == ST_BURST);
  assign eff_cap  = (CW'(cap_q) > DEPTH_C) ? DEPTH_C : CW'(cap_q);
  assign wr_ok    = !closed_q && (held_q < eff_cap);
  assign len_clip = (length_i > BURST_C) ? BURST_C : length_i;
  assign len_cap  = CW'(len_clip);
  assign len_full = CW'(length_i);
  assign n_rd     = (len_cap > held_q) ? held_q : len_cap;
  assign n_dc     = (len_full > held_q) ? held_q : len_full;
  assign n_sel    = (req_type_i == REQ_DISCARD) ? n_dc : n_rd;
  assign head_sum = {1'b0, head_q} + n_sel[AW:0];
  assign space    = (held_q >= eff_cap) ? '0 : eff_cap - held_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_READ || req_type_i == REQ_PEEK)
            && n_rd != '0) begin
          state_d = ST_BURST;
        end
      end
      ST_BURST: begin
        if (remain_q == LEN_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    held_d       = held_q;
    closed_d     = closed_q;
    wr_tot_d     = wr_tot_q;
    rd_tot_d     = rd_tot_q;
    rd_ptr_d     = rd_ptr_q;
    remain_d     = remain_q;
    valid_d      = 1'b0;
    bvalid_d     = 1'b0;
    last_d       = 1'b0;
    acc_d        = 1'b0;
    mem_ctl_o.we = 1'b0;
    mem_ctl_o.re = 1'b0;
    if (state_q == ST_BURST) begin
      mem_ctl_o.re = 1'b1;
      rd_ptr_d     = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
      remain_d     = remain_q - LEN_W'(1);
      valid_d      = 1'b1;
      bvalid_d     = 1'b1;
      last_d       = (remain_q == LEN_W'(1));
    end else if (accept) begin
      valid_d = 1'b1;
      last_d  = 1'b1;
      case (req_type_i) inside
        REQ_WRITE: begin
          acc_d = wr_ok;
          if (wr_ok) begin
            mem_ctl_o.we = 1'b1;
            tail_d       = (tail_q == LAST_PTR) ? '0 : tail_q + AW'(1);
            held_d       = held_q + CW'(1);
            wr_tot_d     = wr_tot_q + TOT_W'(1);
          end
        end
        REQ_READ, REQ_PEEK, REQ_DISCARD: begin
          if (req_type_i != REQ_DISCARD && n_rd != '0) begin
            valid_d  = 1'b0;
            last_d   = 1'b0;
            rd_ptr_d = head_q;
            remain_d = LEN_W'(n_rd);
          end
          if (req_type_i != REQ_PEEK) begin
            head_d   = (head_sum >= DEPTH_P) ? AW'(head_sum - DEPTH_P) : AW'(head_sum);
            held_d   = held_q - n_sel;
            rd_tot_d = rd_tot_q + TOT_W'(n_sel);
          end
        end
        REQ_CLOSE: closed_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      held_q   <= '0;
      closed_q <= 1'b0;
      wr_tot_q <= '0;
      rd_tot_q <= '0;
      cap_q    <= CAP_RESET;
      rd_ptr_q <= '0;
      remain_q <= '0;
      valid_q  <= 1'b0;
      bvalid_q <= 1'b0;
      last_q   <= 1'b0;
      acc_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      held_q   <= held_d;
      closed_q <= closed_d;
      wr_tot_q <= wr_tot_d;
      rd_tot_q <= rd_tot_d;
      rd_ptr_q <= rd_ptr_d;
      remain_q <= remain_d;
      valid_q  <= valid_d;
      bvalid_q <= bvalid_d;
      last_q   <= last_d;
      acc_q    <= acc_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  assign mem_waddr_o     = tail_q;
  assign mem_raddr_o     = rd_ptr_q;
  assign valid_o         = valid_q;
  assign byte_valid_o    = bvalid_q;
  assign last_o          = last_q;
  assign accepted_o      = acc_q;
  assign out_byte_o      = bvalid_q ? mem_rdata_i : '0;
  assign fill_level_o    = STAT_W'(held_q);
  assign space_left_o    = STAT_W'(space);
  assign input_closed_o  = closed_q;
  assign end_of_stream_o = closed_q && (held_q == '0);
  assign total_written_o = wr_tot_q;
  assign total_read_o    = rd_tot_q;

endmodule
`default_nettype wire

// ===== design/flow_controlled_byte_fifo_top.sv =====
// Top level of the flow-controlled byte FIFO.
// Results are registered: status in the cycle after acceptance; read bytes at 1 per cycle.
// Write, discard, close and empty reads: one transaction per cycle, busy stays low.
// Read or peek of n bytes: busy while the n bytes are read; no transaction is taken while busy.
// Reset clears pointers, counts, totals and flags and sets capacity to 4096;
// the byte RAM is not cleared. Results cannot be stalled.
`default_nettype none
module flow_controlled_byte_fifo_top
  import fcbf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned MAX_BURST   = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [DATA_W-1:0] data_byte_i,
  input  wire logic [LEN_W-1:0]  length_i,
  input  wire logic              cfg_we_i,
  input  wire logic [STAT_W-1:0] cfg_wdata_i,
  output logic                   valid_o,
  output logic      [DATA_W-1:0] out_byte_o,
  output logic                   byte_valid_o,
  output logic                   last_o,
  output logic                   accepted_o,
  output logic      [STAT_W-1:0] fill_level_o,
  output logic      [STAT_W-1:0] space_left_o,
  output logic                   input_closed_o,
  output logic                   end_of_stream_o,
  output logic      [TOT_W-1:0]  total_written_o,
  output logic      [TOT_W-1:0]  total_read_o
);

  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > STAT_W) ? CNT_W : STAT_W;

  mem_ctl_t          mem_ctl;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  fcbf_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (data_byte_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fcbf_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_BURST   (MAX_BURST),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .length_i        (length_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mem_ctl_o       (mem_ctl),
    .mem_waddr_o     (mem_waddr),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .valid_o         (valid_o),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .last_o          (last_o),
    .accepted_o      (accepted_o),
    .fill_level_o    (fill_level_o),
    .space_left_o    (space_left_o),
    .input_closed_o  (input_closed_o),
    .end_of_stream_o (end_of_stream_o),
    .total_written_o (total_written_o),
    .total_read_o    (total_read_o)
  );

endmodule
`default_nettype wire

// ===== design/fcbf_checker.sv =====
// Port-level checks for the byte FIFO and their binding to the top level.
`default_nettype none
module fcbf_checker
  import fcbf_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              valid_o,
  input wire logic              byte_valid_o,
  input wire logic              last_o,
  input wire logic              accepted_o,
  input wire logic [STAT_W-1:0] fill_level_o,
  input wire logic              input_closed_o,
  input wire logic              end_of_stream_o
);

  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> valid_o || busy)
    else $error("accepted transaction produced neither result nor burst");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o && byte_valid_o)
    else $error("burst interrupted before last byte");

  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && accepted_o |-> !byte_valid_o && last_o)
    else $error("write acceptance on a byte result");

  a_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(input_closed_o) |-> input_closed_o)
    else $error("closed flag dropped");

  a_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_of_stream_o == (input_closed_o && fill_level_o == '0))
    else $error("end of stream inconsistent with status");

endmodule

bind flow_controlled_byte_fifo_top fcbf_checker u_fcbf_checker (.*);
`default_nettype wire

// ===== tb/fcbf_checker.sv =====
// Checker for the byte FIFO: tracks FIFO state, predicts each result and compares it.
module fcbf_tb_checker
  import fcbf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 4096,
  parameter int unsigned MAX_BURST   = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [DATA_W-1:0] data_byte_i,
  input  wire logic [LEN_W-1:0]  length_i,
  input  wire logic              cfg_we_i,
  input  wire logic [STAT_W-1:0] cfg_wdata_i,
  input  wire logic              valid_o,
  input  wire logic [DATA_W-1:0] out_byte_o,
  input  wire logic              byte_valid_o,
  input  wire logic              last_o,
  input  wire logic              accepted_o,
  input  wire logic [STAT_W-1:0] fill_level_o,
  input  wire logic [STAT_W-1:0] space_left_o,
  input  wire logic              input_closed_o,
  input  wire logic              end_of_stream_o,
  input  wire logic [TOT_W-1:0]  total_written_o,
  input  wire logic [TOT_W-1:0]  total_read_o,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PTR_W = $clog2(STORE_DEPTH);

  typedef struct {
    logic [DATA_W-1:0] out_byte;
    logic              byte_valid;
    logic              is_last;
    logic              accepted;
    logic [STAT_W-1:0] fill_level;
    logic [STAT_W-1:0] space_left;
    logic              input_closed;
    logic              end_of_stream;
    logic [TOT_W-1:0]  total_written;
    logic [TOT_W-1:0]  total_read;
  } fifo_result_t;

  fifo_result_t      owed_results[$];
  logic [DATA_W-1:0] byte_copy [STORE_DEPTH];
  logic [PTR_W-1:0]  head_ptr;
  logic [PTR_W-1:0]  tail_ptr;
  logic [STAT_W-1:0] held;
  logic [STAT_W-1:0] capacity;
  logic              closed;
  logic [TOT_W-1:0]  written_sum;
  logic [TOT_W-1:0]  removed_sum;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [STAT_W-1:0] usable_capacity();
    return (capacity > STORE_DEPTH) ? STAT_W'(STORE_DEPTH) : capacity;
  endfunction

  function automatic fifo_result_t status_now(input logic [DATA_W-1:0] b, input logic bv,
                                              input logic lst, input logic acc);
    fifo_result_t r;
    logic [STAT_W-1:0] ce;
    ce              = usable_capacity();
    r.out_byte      = b;
    r.byte_valid    = bv;
    r.is_last       = lst;
    r.accepted      = acc;
    r.fill_level    = held;
    r.space_left    = (held >= ce) ? '0 : ce - held;
    r.input_closed  = closed;
    r.end_of_stream = closed && (held == '0);
    r.total_written = written_sum;
    r.total_read    = removed_sum;
    return r;
  endfunction

  task automatic run_request(input logic [REQ_W-1:0] rq, input logic [DATA_W-1:0] db,
                             input logic [LEN_W-1:0] ln);
    logic [DATA_W-1:0] got [MAX_BURST];
    logic [PTR_W-1:0]  p;
    int unsigned       n;
    logic              acc;
    n   = 0;
    acc = 1'b0;
    case (rq) inside
      REQ_WRITE: begin
        acc = !closed && (held < usable_capacity());
        if (acc) begin
          byte_copy[tail_ptr] = db;
          tail_ptr    = next_ptr(tail_ptr);
          held        = held + 1'b1;
          written_sum = written_sum + 1'b1;
        end
        owed_results.push_back(status_now('0, 1'b0, 1'b1, acc));
      end
      REQ_READ, REQ_PEEK: begin
        n = ln;
        if (n > MAX_BURST) n = MAX_BURST;
        if (n > held) n = held;
        p = head_ptr;
        for (int i = 0; i < n; i++) begin
          got[i] = byte_copy[p];
          p      = next_ptr(p);
        end
        if (rq == REQ_READ) begin
          head_ptr    = p;
          held        = held - STAT_W'(n);
          removed_sum = removed_sum + TOT_W'(n);
        end
        if (n == 0) begin
          owed_results.push_back(status_now('0, 1'b0, 1'b1, 1'b0));
        end else begin
          for (int i = 0; i < n; i++)
            owed_results.push_back(status_now(got[i], 1'b1, i == n - 1, 1'b0));
        end
      end
      REQ_DISCARD: begin
        n = (ln > held) ? held : ln;
        for (int i = 0; i < n; i++) head_ptr = next_ptr(head_ptr);
        held        = held - STAT_W'(n);
        removed_sum = removed_sum + TOT_W'(n);
        owed_results.push_back(status_now('0, 1'b0, 1'b1, 1'b0));
      end
      REQ_CLOSE: begin
        closed = 1'b1;
        owed_results.push_back(status_now('0, 1'b0, 1'b1, 1'b0));
      end
      default: begin
        owed_results.push_back(status_now('0, 1'b0, 1'b1, 1'b0));
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fifo_result_t want;
    if (!rst_ni) begin
      owed_results.delete();
      head_ptr    = '0;
      tail_ptr    = '0;
      held        = '0;
      capacity    = CAP_RESET;
      closed      = 1'b0;
      written_sum = '0;
      removed_sum = '0;
      pending    <= 0;
    end else begin
      if ($isunknown(valid_o)) begin
        $error("valid_o is unknown");
        fail_count++;
      end else if (valid_o) begin
        if (owed_results.size() == 0) begin
          $error("result with no transaction waiting for it");
          fail_count++;
        end else begin
          want = owed_results[0];
          owed_results.delete(0);
          compare_field("out_byte", 32'(want.out_byte), 32'(out_byte_o));
          compare_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid_o));
          compare_field("last", 32'(want.is_last), 32'(last_o));
          compare_field("accepted", 32'(want.accepted), 32'(accepted_o));
          compare_field("fill_level", 32'(want.fill_level), 32'(fill_level_o));
          compare_field("space_left", 32'(want.space_left), 32'(space_left_o));
          compare_field("input_closed", 32'(want.input_closed), 32'(input_closed_o));
          compare_field("end_of_stream", 32'(want.end_of_stream), 32'(end_of_stream_o));
          compare_field("total_written", want.total_written, total_written_o);
          compare_field("total_read", want.total_read, total_read_o);
        end
      end
      if (start && !busy) run_request(req_type_i, data_byte_i, length_i);
      if (cfg_we_i) capacity = cfg_wdata_i;
      pending <= owed_results.size();
    end
  end

endmodule

// ===== tb/tb_flow_controlled_byte_fifo_top.sv =====
// Testbench top for the byte FIFO: clock, reset, request stimulus and the verdict.
module tb_flow_controlled_byte_fifo_top;
  import fcbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic [REQ_W-1:0]  req_type_i  = '0;
  logic [DATA_W-1:0] data_byte_i = '0;
  logic [LEN_W-1:0]  length_i    = '0;
  logic              cfg_we_i    = 1'b0;
  logic [STAT_W-1:0] cfg_wdata_i = '0;
  logic              busy;
  logic              valid_o;
  logic [DATA_W-1:0] out_byte_o;
  logic              byte_valid_o;
  logic              last_o;
  logic              accepted_o;
  logic [STAT_W-1:0] fill_level_o;
  logic [STAT_W-1:0] space_left_o;
  logic              input_closed_o;
  logic              end_of_stream_o;
  logic [TOT_W-1:0]  total_written_o;
  logic [TOT_W-1:0]  total_read_o;
  int                fail_count;
  int                pending;
  int                sent_items = 0;
  int                end_errors = 0;
  bit                gaps_on    = 1'b1;

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  flow_controlled_byte_fifo_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .data_byte_i    (data_byte_i),
    .length_i       (length_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .valid_o        (valid_o),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o),
    .accepted_o     (accepted_o),
    .fill_level_o   (fill_level_o),
    .space_left_o   (space_left_o),
    .input_closed_o (input_closed_o),
    .end_of_stream_o(end_of_stream_o),
    .total_written_o(total_written_o),
    .total_read_o   (total_read_o)
  );

  fcbf_tb_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .data_byte_i    (data_byte_i),
    .length_i       (length_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .valid_o        (valid_o),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_o         (last_o),
    .accepted_o     (accepted_o),
    .fill_level_o   (fill_level_o),
    .space_left_o   (space_left_o),
    .input_closed_o (input_closed_o),
    .end_of_stream_o(end_of_stream_o),
    .total_written_o(total_written_o),
    .total_read_o   (total_read_o),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end

  // returns at the edge that takes the transaction, start left high
  task automatic send(input logic [REQ_W-1:0] rq, input logic [DATA_W-1:0] db,
                      input logic [LEN_W-1:0] ln);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 7) begin
        start       <= 1'b0;
        req_type_i  <= REQ_W'($urandom);
        data_byte_i <= DATA_W'($urandom);
        length_i    <= LEN_W'($urandom);
        @(posedge clk_i);
      end
    end
    start       <= 1'b1;
    req_type_i  <= rq;
    data_byte_i <= db;
    length_i    <= ln;
    do @(posedge clk_i); while (busy);
    sent_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [STAT_W-1:0] cap);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(1, 8));
    if (r < 85) return LEN_W'($urandom_range(0, 127));
    return LEN_W'($urandom_range(60, 127));
  endfunction

  task automatic random_phase(input int count, input bit allow_close);
    int stop_at;
    int unsigned r;
    int k;
    stop_at = sent_items + count;
    while (sent_items < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        k = $urandom_range(1, 12);
        repeat (k) send(REQ_WRITE, DATA_W'($urandom), LEN_W'($urandom));
      end else if (r < 58) begin
        send(REQ_READ, DATA_W'($urandom), pick_len());
      end else if (r < 72) begin
        send(REQ_PEEK, DATA_W'($urandom), pick_len());
      end else if (r < 84) begin
        send(REQ_DISCARD, DATA_W'($urandom), pick_len());
      end else if (r < 92) begin
        send(REQ_W'($urandom_range(allow_close ? 4 : 5, 7)), DATA_W'($urandom),
             LEN_W'($urandom));
      end else begin
        send(REQ_WRITE, DATA_W'($urandom), LEN_W'($urandom));
        send(REQ_PEEK, DATA_W'($urandom), LEN_W'(1));
      end
    end
  endtask

  initial begin
    int guard;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty FIFO, zero-length, undefined request and capacity-limit cases
    send(REQ_READ, 8'h00, 7'd1);
    send(REQ_PEEK, 8'h00, 7'd0);
    send(REQ_DISCARD, 8'h00, 7'd5);
    send(REQ_WRITE, 8'h00, 7'd0);
    send(REQ_WRITE, 8'hFF, 7'd127);
    send(REQ_WRITE, 8'hA5, 7'd0);
    send(REQ_WRITE, 8'h5A, 7'd0);
    send(REQ_PEEK, 8'h00, 7'd2);
    send(REQ_READ, 8'h00, 7'd0);
    send(REQ_READ, 8'h00, 7'd1);
    send(REQ_DISCARD, 8'h00, 7'd0);
    send(REQ_W'(5), 8'h00, 7'd0);
    send(REQ_W'(6), 8'hFF, 7'd127);
    send(REQ_W'(7), 8'h3C, 7'd64);
    send(REQ_READ, 8'h00, 7'd127);
    send(REQ_WRITE, 8'h81, 7'd0);
    set_capacity(13'd0);
    send(REQ_WRITE, 8'h42, 7'd0);
    set_capacity(13'd2);
    send(REQ_WRITE, 8'h11, 7'd0);
    send(REQ_WRITE, 8'h22, 7'd0);
    send(REQ_WRITE, 8'h33, 7'd0);
    send(REQ_DISCARD, 8'h00, 7'd127);
    set_capacity(13'd8191);
    send(REQ_WRITE, 8'h7E, 7'd0);
    send(REQ_PEEK, 8'h00, 7'd127);

    set_capacity(13'd8);
    random_phase(50, 1'b0);
    set_capacity(13'd1);
    random_phase(30, 1'b0);
    set_capacity(13'd0);
    random_phase(20, 1'b0);

    gaps_on = 1'b0;
    set_capacity(13'd64);
    random_phase(30, 1'b0);
    gaps_on = 1'b1;

    set_capacity(13'd8191);
    repeat (80) send(REQ_WRITE, DATA_W'($urandom), LEN_W'($urandom));
    send(REQ_PEEK, 8'h00, 7'd127);
    send(REQ_READ, 8'h00, 7'd100);
    random_phase(20, 1'b0);
    drain();
    random_phase(20, 1'b0);

    set_capacity(13'd5000);
    random_phase(30, 1'b0);

    // capacity dropped under the current fill
    set_capacity(13'd32);
    send(REQ_DISCARD, 8'h00, 7'd127);
    repeat (20) send(REQ_WRITE, DATA_W'($urandom), LEN_W'($urandom));
    set_capacity(13'd6);
    random_phase(30, 1'b0);

    set_capacity(13'd4096);
    random_phase(20, 1'b0);

    send(REQ_CLOSE, 8'h00, 7'd0);
    send(REQ_CLOSE, 8'hFF, 7'd127);
    send(REQ_WRITE, 8'h99, 7'd0);
    random_phase(30, 1'b1);
    send(REQ_READ, 8'h00, 7'd64);
    send(REQ_READ, 8'h00, 7'd64);
    send(REQ_DISCARD, 8'h00, 7'd127);
    send(REQ_PEEK, 8'h00, 7'd1);

    start <= 1'b0;
    @(posedge clk_i);
    guard = 0;
    while (pending != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending != 0) begin
      $error("results still owed at end: %0d", pending);
      end_errors++;
    end
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && end_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== flow_controlled_byte_fifo_top.f =====
design/fcbf_pkg.sv
design/fcbf_mem.sv
design/fcbf_ctrl.sv
design/flow_controlled_byte_fifo_top.sv
design/fcbf_checker.sv
tb/fcbf_checker.sv
tb/tb_flow_controlled_byte_fifo_top.sv
